// ===== design/trca_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trca_pkg
// Shared types and constants for the touch report calibrate/assemble block.
// ----------------------------------------------------------------------------
package trca_pkg;

  localparam int COORD_W  = 12;
  localparam int GAIN_W   = 16;
  localparam int CNT_W    = 5;   // holds a frame count up to the largest slot count
  localparam int PROD_W   = COORD_W + GAIN_W;
  localparam int DIVIN_W  = 19;  // products below the saturation limit, divided by 8
  localparam int RECIP_W  = 20;
  localparam int QPROD_W  = DIVIN_W + RECIP_W;

  localparam logic [COORD_W-1:0] COORD_MAX    = 12'hFFF;
  localparam logic [7:0]         RELEASE_CODE = 8'h80;
  localparam logic [7:0]         TOUCH_SIZE   = 8'd128;

  // divide by 1000: drop 3 bits, then floor(a / 125) = (a * ceil(2^26 / 125)) >> 26
  localparam logic [RECIP_W-1:0] RECIP_M     = 20'd536871;
  localparam int                 RECIP_SHIFT = 26;
  localparam logic [PROD_W-1:0]  SAT_LIMIT   = 28'd4096000;  // 4096 * 1000

  // configuration register indexes
  localparam logic [2:0] REG_CALIB_ENABLE = 3'd0;
  localparam logic [2:0] REG_MIN_X        = 3'd1;
  localparam logic [2:0] REG_MAX_X        = 3'd2;
  localparam logic [2:0] REG_MIN_Y        = 3'd3;
  localparam logic [2:0] REG_MAX_Y        = 3'd4;
  localparam logic [2:0] REG_GAIN_X       = 3'd5;
  localparam logic [2:0] REG_GAIN_Y       = 3'd6;

  typedef struct packed {
    logic [7:0]         contact_count;
    logic [7:0]         contact_index;
    logic [COORD_W-1:0] raw_x;
    logic [COORD_W-1:0] raw_y;
  } in_item_t;

  typedef struct packed {
    logic               release_res;
    logic [2:0]         slot;
    logic [COORD_W-1:0] pos_x;
    logic [COORD_W-1:0] pos_y;
    logic [7:0]         touch_size;
    logic               last;
  } out_item_t;

  typedef struct packed {
    logic               enable;
    logic [COORD_W-1:0] min_x;
    logic [COORD_W-1:0] max_x;
    logic [COORD_W-1:0] min_y;
    logic [COORD_W-1:0] max_y;
    logic [GAIN_W-1:0]  gain_x;
    logic [GAIN_W-1:0]  gain_y;
  } calib_t;

  // work handed from the front to the back
  typedef struct packed {
    logic             release_cmd;
    logic [CNT_W-1:0] count;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

endpackage

// ===== design/trca_cmdq.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trca_cmdq
// Two-entry command queue between the front and the back.
// ----------------------------------------------------------------------------
module trca_cmdq (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  trca_pkg::cmd_t   wr_data,
  input  logic             rd_en,
  output trca_pkg::cmd_t   rd_data,
  output trca_pkg::q_status_t status
);
  import trca_pkg::*;

  cmd_t       mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (wr_en) wr_ptr <= ~wr_ptr;
      if (rd_en) rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, wr_en} - {1'b0, rd_en};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_ptr] <= wr_data;
  end

  assign rd_data      = mem[rd_ptr];
  assign status.empty = (fill == 2'd0);
  assign status.full  = (fill == 2'd2);

endmodule

// ===== design/trca_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trca_front
// Accepts reports, inverts and calibrates, stores slots, issues commands.
// ----------------------------------------------------------------------------
module trca_front #(
  parameter int MAX_FINGERS = 5,
  parameter int SW          = 3
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  output logic                 full,
  input  trca_pkg::in_item_t   item,
  input  trca_pkg::calib_t     calib,
  input  trca_pkg::q_status_t  q_stat,
  input  logic                 back_busy,
  output logic                 cmd_wr,
  output trca_pkg::cmd_t       cmd,
  input  logic [SW-1:0]        rd_idx,
  output logic [trca_pkg::COORD_W-1:0] rd_x,
  output logic [trca_pkg::COORD_W-1:0] rd_y
);
  import trca_pkg::*;

  typedef enum logic [4:0] {
    F_IDLE   = 5'b00001,
    F_CLAMP  = 5'b00010,
    F_MUL    = 5'b00100,
    F_DIV    = 5'b01000,
    F_COMMIT = 5'b10000
  } fstate_t;

  fstate_t            state;
  fstate_t            state_next;
  logic [7:0]         count;
  logic [7:0]         idx;
  logic [COORD_W-1:0] inv_x;
  logic [COORD_W-1:0] inv_y;
  logic [COORD_W-1:0] off_x;
  logic [COORD_W-1:0] off_y;
  logic [PROD_W-1:0]  prod_x;
  logic [PROD_W-1:0]  prod_y;
  logic [QPROD_W-1:0] qprod_x;
  logic [QPROD_W-1:0] qprod_y;
  logic               sat_x;
  logic               sat_y;
  logic [COORD_W-1:0] slot_x [MAX_FINGERS];
  logic [COORD_W-1:0] slot_y [MAX_FINGERS];

  logic               idx_ok;
  logic               is_release;
  logic               is_frame;
  logic               need_cmd;
  logic               commit_go;
  logic [SW-1:0]      wr_idx;
  logic [COORD_W-1:0] fin_x;
  logic [COORD_W-1:0] fin_y;

  function automatic logic [COORD_W-1:0] clamp_off(input logic [COORD_W-1:0] v,
                                                   input logic [COORD_W-1:0] lo,
                                                   input logic [COORD_W-1:0] hi);
    logic [COORD_W-1:0] t;
    t = (v >= hi) ? hi : v;
    if (t < lo) t = lo;
    return t - lo;
  endfunction

  assign idx_ok     = (idx != 8'd0) && (idx <= 8'(MAX_FINGERS));
  assign is_release = (count == RELEASE_CODE);
  assign is_frame   = idx_ok && (count == idx);
  assign need_cmd   = is_release || is_frame;
  assign wr_idx     = SW'(idx - 8'd1);

  // slot writes wait until the back has drained every older frame
  assign commit_go = (!idx_ok || (q_stat.empty && !back_busy)) &&
                     (!need_cmd || !q_stat.full);

  assign fin_x = !calib.enable ? inv_x : (sat_x ? COORD_MAX : qprod_x[RECIP_SHIFT +: COORD_W]);
  assign fin_y = !calib.enable ? inv_y : (sat_y ? COORD_MAX : qprod_y[RECIP_SHIFT +: COORD_W]);

  assign full = (state != F_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE:   if (push) state_next = F_CLAMP;
      F_CLAMP:  state_next = F_MUL;
      F_MUL:    state_next = F_DIV;
      F_DIV:    state_next = F_COMMIT;
      F_COMMIT: if (commit_go) state_next = F_IDLE;
      default:  state_next = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= F_IDLE;
    else     state <= state_next;
  end

  // datapath, one step per state
  always_ff @(posedge clk) begin
    if (state == F_IDLE && push) begin
      count <= item.contact_count;
      idx   <= item.contact_index;
      inv_x <= ~item.raw_x;
      inv_y <= ~item.raw_y;
    end
    if (state == F_CLAMP) begin
      off_x <= clamp_off(inv_x, calib.min_x, calib.max_x);
      off_y <= clamp_off(inv_y, calib.min_y, calib.max_y);
    end
    if (state == F_MUL) begin
      prod_x <= PROD_W'(off_x) * PROD_W'(calib.gain_x);
      prod_y <= PROD_W'(off_y) * PROD_W'(calib.gain_y);
    end
    if (state == F_DIV) begin
      qprod_x <= QPROD_W'(prod_x[3 +: DIVIN_W]) * QPROD_W'(RECIP_M);
      qprod_y <= QPROD_W'(prod_y[3 +: DIVIN_W]) * QPROD_W'(RECIP_M);
      sat_x   <= (prod_x >= SAT_LIMIT);
      sat_y   <= (prod_y >= SAT_LIMIT);
    end
  end

  // slot store
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_FINGERS; i++) begin
        slot_x[i] <= '0;
        slot_y[i] <= '0;
      end
    end else if (state == F_COMMIT && commit_go && idx_ok) begin
      slot_x[wr_idx] <= fin_x;
      slot_y[wr_idx] <= fin_y;
    end
  end

  assign rd_x = slot_x[rd_idx];
  assign rd_y = slot_y[rd_idx];

  assign cmd_wr          = (state == F_COMMIT) && commit_go && need_cmd;
  assign cmd.release_cmd = is_release;
  assign cmd.count       = CNT_W'(idx);

endmodule

// ===== design/trca_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trca_back
// Turns queued commands into result items, one per cycle while the output register is free.
// ----------------------------------------------------------------------------
module trca_back #(
  parameter int SW = 3
) (
  input  logic                 clk,
  input  logic                 rst,
  input  trca_pkg::q_status_t  q_stat,
  input  trca_pkg::cmd_t       q_data,
  output logic                 q_rd,
  output logic                 busy,
  output logic [SW-1:0]        rd_idx,
  input  logic [trca_pkg::COORD_W-1:0] rd_x,
  input  logic [trca_pkg::COORD_W-1:0] rd_y,
  output logic                 empty,
  input  logic                 pop,
  output trca_pkg::out_item_t  result
);
  import trca_pkg::*;

  typedef enum logic [1:0] {
    B_IDLE = 2'b01,
    B_EMIT = 2'b10
  } bstate_t;

  bstate_t   state;
  cmd_t      cur;
  logic [SW-1:0] k;
  logic      out_valid;
  logic      out_free;
  logic      k_last;
  out_item_t res_next;

  assign out_free = !out_valid || pop;
  assign k_last   = cur.release_cmd || ((CNT_W'(k) + CNT_W'(1)) == cur.count);
  assign q_rd     = (state == B_IDLE) && !q_stat.empty;
  assign busy     = (state == B_EMIT);
  assign rd_idx   = k;
  assign empty    = !out_valid;

  always_comb begin
    if (cur.release_cmd) begin
      res_next.release_res = 1'b1;
      res_next.slot        = 3'd0;
      res_next.pos_x       = '0;
      res_next.pos_y       = '0;
      res_next.touch_size  = 8'd0;
      res_next.last        = 1'b1;
    end else begin
      res_next.release_res = 1'b0;
      res_next.slot        = 3'(k);
      res_next.pos_x       = rd_x;
      res_next.pos_y       = rd_y;
      res_next.touch_size  = TOUCH_SIZE;
      res_next.last        = k_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= B_IDLE;
      out_valid <= 1'b0;
      k         <= '0;
    end else begin
      unique case (state)
        B_IDLE: begin
          if (!q_stat.empty) begin
            state <= B_EMIT;
            k     <= '0;
          end
        end
        B_EMIT: begin
          if (out_free) begin
            if (k_last) state <= B_IDLE;
            else        k <= k + SW'(1);
          end
        end
        default: state <= B_IDLE;
      endcase
      // a new result fills the register, a pop alone empties it
      if (state == B_EMIT && out_free) out_valid <= 1'b1;
      else if (pop)                    out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_rd) cur <= q_data;
    if (state == B_EMIT && out_free) result <= res_next;
  end

endmodule

// ===== design/touch_report_calibrate_assemble_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// touch_report_calibrate_assemble_core
// Touch report calibration and frame assembly.
// ----------------------------------------------------------------------------
// Each report pushed in is inverted (4095 - raw), optionally clamped to the
// min/max window, offset by min, scaled by gain/1000 and saturated at 4095,
// then stored in the slot of its one-based contact index (indexes of 0 or
// above MAX_FINGERS store nothing). A report whose count equals its index
// completes a frame and pops out one result per stored slot 0..count-1, the
// final one flagged last. A count of 0x80 pops out a single release result
// instead. The front takes one report at a time through its accept, clamp,
// multiply, reciprocal divide and commit steps; results leave at one per
// cycle from a single output register while pop keeps it free. A report
// that writes a slot holds in commit until the back has finished emitting
// every earlier frame, so the next slot write waits for the results of the
// frame before it, and waits longer while pop is held low.
// Configuration may be written whenever the block is idle; cfg_ready is
// always high.
// ----------------------------------------------------------------------------
module touch_report_calibrate_assemble_core #(
  parameter int MAX_FINGERS = 5
) (
  input  logic                clk,
  input  logic                rst,
  // report input
  input  logic                push,
  output logic                full,
  input  trca_pkg::in_item_t  item,
  // result output
  output logic                empty,
  input  logic                pop,
  output trca_pkg::out_item_t result,
  // configuration writes
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [2:0]          cfg_index,
  input  logic [15:0]         cfg_data
);
  import trca_pkg::*;

  // slot index width
  localparam int SW = (MAX_FINGERS > 1) ? $clog2(MAX_FINGERS) : 1;

  calib_t             calib;
  q_status_t          q_stat;
  cmd_t               cmd_in;
  cmd_t               cmd_out;
  logic               cmd_wr;
  logic               cmd_rd;
  logic               back_busy;
  logic [SW-1:0]      rd_idx;
  logic [COORD_W-1:0] rd_x;
  logic [COORD_W-1:0] rd_y;

  assign cfg_ready = 1'b1;

  // configuration registers, unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      calib.enable <= 1'b0;
      calib.min_x  <= '0;
      calib.max_x  <= COORD_MAX;
      calib.min_y  <= '0;
      calib.max_y  <= COORD_MAX;
      calib.gain_x <= 16'd1000;
      calib.gain_y <= 16'd1000;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_CALIB_ENABLE: calib.enable <= cfg_data[0];
        REG_MIN_X:        calib.min_x  <= cfg_data[COORD_W-1:0];
        REG_MAX_X:        calib.max_x  <= cfg_data[COORD_W-1:0];
        REG_MIN_Y:        calib.min_y  <= cfg_data[COORD_W-1:0];
        REG_MAX_Y:        calib.max_y  <= cfg_data[COORD_W-1:0];
        REG_GAIN_X:       calib.gain_x <= cfg_data;
        REG_GAIN_Y:       calib.gain_y <= cfg_data;
        default: ;
      endcase
    end
  end

  // front: accept, calibrate, store, issue commands
  trca_front #(
    .MAX_FINGERS (MAX_FINGERS),
    .SW          (SW)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .item      (item),
    .calib     (calib),
    .q_stat    (q_stat),
    .back_busy (back_busy),
    .cmd_wr    (cmd_wr),
    .cmd       (cmd_in),
    .rd_idx    (rd_idx),
    .rd_x      (rd_x),
    .rd_y      (rd_y)
  );

  // command queue lets the front finish while results drain
  trca_cmdq u_cmdq (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (cmd_wr),
    .wr_data (cmd_in),
    .rd_en   (cmd_rd),
    .rd_data (cmd_out),
    .status  (q_stat)
  );

  // back: walk the slots and feed the output register
  trca_back #(
    .SW (SW)
  ) u_back (
    .clk    (clk),
    .rst    (rst),
    .q_stat (q_stat),
    .q_data (cmd_out),
    .q_rd   (cmd_rd),
    .busy   (back_busy),
    .rd_idx (rd_idx),
    .rd_x   (rd_x),
    .rd_y   (rd_y),
    .empty  (empty),
    .pop    (pop),
    .result (result)
  );

endmodule

// ===== design/trca_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// trca_checker
// Port-level checks for the touch report calibrate/assemble block.
// ----------------------------------------------------------------------------
module trca_checker (
  input logic                clk,
  input logic                rst,
  input logic                push,
  input logic                full,
  input logic                empty,
  input logic                pop,
  input trca_pkg::out_item_t result
);
  import trca_pkg::*;

  // reset leaves nothing to pop and room for a report
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (empty && !full))
    else $error("not idle after reset");

  // one report at a time: an accepted report blocks the input
  a_busy_after_push: assert property (@(posedge clk) disable iff (rst)
    (push && !full) |=> full)
    else $error("input open right after a report was taken");

  // a waiting result holds until popped
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(result)))
    else $error("waiting result changed");

  // release results are fixed
  a_release_fmt: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.release_res) |->
      (result.last && result.touch_size == 8'd0 && result.slot == 3'd0 &&
       result.pos_x == '0 && result.pos_y == '0))
    else $error("malformed release result");

  // contact results carry the fixed touch size
  a_contact_size: assert property (@(posedge clk) disable iff (rst)
    (!empty && !result.release_res) |-> (result.touch_size == TOUCH_SIZE))
    else $error("contact result with wrong touch size");

endmodule

bind touch_report_calibrate_assemble_core trca_checker u_trca_checker (.*);
